[hw/rtl/sds_pkg.sv]
// Shared types, constants and helpers for the SMTP body dot-stuffing encoder.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_NUL = 8'h00;

    // Fixed output slots of one job: CR LF . . byte CR LF . CR LF
    localparam int unsigned NUM_POS  = 10;
    localparam int unsigned POS_BYTE = 4;
    localparam int unsigned POS_EOM  = 9;
    localparam int unsigned POS_W    = 4;

    typedef enum logic [2:0] {
        M_MIDLINE     = 3'd0,
        M_BOM         = 3'd1,
        M_CR          = 3'd2,
        M_CRLF        = 3'd3,
        M_CRLF_DOT    = 3'd4,
        M_CRLF_DOT_CR = 3'd5,
        M_DOT         = 3'd6,
        M_DOT_CR      = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        CL_PLAIN = 3'd0,
        CL_END   = 3'd1,
        CL_LF    = 3'd2,
        CL_CR    = 3'd3,
        CL_DOT   = 3'd4,
        CL_HIGH  = 3'd5
    } t_class;

    // One decoded item: which groups of bytes to send, in slot order.
    typedef struct packed {
        logic       crlf;
        logic       dots;
        logic       pass;
        logic       term;
        logic [7:0] data;
    } t_job;

    function automatic t_class byte_class(input logic [7:0] b);
        t_class c;
        if (b == CH_NUL)      c = CL_END;
        else if (b == CH_LF)  c = CL_LF;
        else if (b == CH_CR)  c = CL_CR;
        else if (b == CH_DOT) c = CL_DOT;
        else if (b[7])        c = CL_HIGH;
        else                  c = CL_PLAIN;
        return c;
    endfunction

    function automatic logic [NUM_POS-1:0] job_mask(input t_job j);
        return {{5{j.term}}, j.pass, {2{j.dots}}, {2{j.crlf}}};
    endfunction

    function automatic logic [7:0] slot_byte(input logic [POS_W-1:0] p);
        logic [7:0] b;
        case (p)
            4'd0, 4'd5, 4'd8: b = CH_CR;
            4'd1, 4'd6, 4'd9: b = CH_LF;
            default:          b = CH_DOT;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/smtp_body_dot_stuffer.sv]
// Top level of the SMTP body dot-stuffing encoder: front end, job queue, byte emitter.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   input   | in        | i_valid / o_ready  | i_in_byte[7:0]
//   output  | out       | o_valid / i_ready  | o_out_byte[7:0], o_last_of_item, o_end_of_message
//
// Cycles: the front end takes one item per cycle while the job queue has room;
//   the emitter sends one byte per cycle unless stalled by i_ready; an item
//   yields 0 to 9 bytes. Items yielding no byte never enter the queue.
// Reset: synchronous, active low; mode returns to begin-of-message, queue and
//   output register empty. No clearing pass.
// Stalls: o_ready drops only when the queue is full; output backpressure stalls
//   the emitter alone until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module smtp_body_dot_stuffer #(
    parameter int unsigned P_QUEUE_DEPTH = sds_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_in_byte,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_end_of_message
);

    // Jobs travel front -> queue -> back.
    sds_pkg::t_job  push_job, head_job;
    sds_pkg::t_mode mode;
    logic           push, pop, q_empty, q_full;

    // Classify and decide; hold the line-start mode.
    sds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (push_job),
        .o_mode    (mode)
    );

    // Decouple decode from the byte-serial drain.
    sds_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Advance through the job's slots, one byte per cycle while the output is not stalled.
    sds_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_q_empty        (q_empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_item   (o_last_of_item),
        .o_end_of_message (o_end_of_message)
    );

    // Never write into a full queue or pop an empty one.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full) && !(pop && q_empty))
        else $error("job queue overflow or underflow");

    // The terminator LF closes its item.
    a_eom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_message) |-> (o_last_of_item && (o_out_byte == sds_pkg::CH_LF)))
        else $error("end of message not on final LF");

    // An accepted zero byte returns the mode machine to begin-of-message.
    a_end_to_bom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_in_byte == sds_pkg::CH_NUL)) |=> (mode == sds_pkg::M_BOM))
        else $error("mode not reset after end of message");

endmodule
`default_nettype wire

[hw/rtl/sds_front.sv]
// Front end: classify each byte, run the mode machine, emit at most one job per item.
`timescale 1ns / 1ps
`default_nettype none
module sds_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [7:0]         i_in_byte,
    input  wire                i_q_full,
    output logic               o_push,
    output sds_pkg::t_job      o_job,
    output sds_pkg::t_mode     o_mode
);

    sds_pkg::t_mode  r_mode, n_mode;
    sds_pkg::t_class cls;
    logic            accept;
    sds_pkg::t_job   job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign cls     = sds_pkg::byte_class(i_in_byte);
    assign o_mode  = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sds_pkg::M_BOM;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        job      = '0;
        job.data = i_in_byte;
        unique case (r_mode)
            sds_pkg::M_MIDLINE, sds_pkg::M_BOM, sds_pkg::M_CR: begin
                case (cls)
                    sds_pkg::CL_PLAIN: begin
                        job.pass = 1'b1;
                        n_mode   = sds_pkg::M_MIDLINE;
                    end
                    sds_pkg::CL_END: begin
                        job.term = 1'b1;
                        n_mode   = sds_pkg::M_BOM;
                    end
                    sds_pkg::CL_LF: begin
                        if (r_mode == sds_pkg::M_CR) n_mode = sds_pkg::M_CRLF;
                    end
                    sds_pkg::CL_CR: begin
                        n_mode = sds_pkg::M_CR;
                    end
                    sds_pkg::CL_DOT: begin
                        if (r_mode == sds_pkg::M_MIDLINE) job.pass = 1'b1;
                        else                              n_mode = sds_pkg::M_DOT;
                    end
                    default: ;
                endcase
            end
            sds_pkg::M_CRLF: begin
                case (cls)
                    sds_pkg::CL_PLAIN: begin
                        job.crlf = 1'b1;
                        job.pass = 1'b1;
                        n_mode   = sds_pkg::M_MIDLINE;
                    end
                    sds_pkg::CL_END: begin
                        // terminator already opens with CRLF
                        job.term = 1'b1;
                        n_mode   = sds_pkg::M_BOM;
                    end
                    sds_pkg::CL_CR: begin
                        job.crlf = 1'b1;
                        n_mode   = sds_pkg::M_CR;
                    end
                    sds_pkg::CL_DOT: n_mode = sds_pkg::M_CRLF_DOT;
                    default: ;
                endcase
            end
            default: begin
                // dot held, possibly after a CRLF and/or followed by a CR
                job.crlf = (r_mode == sds_pkg::M_CRLF_DOT) ||
                           (r_mode == sds_pkg::M_CRLF_DOT_CR);
                case (cls)
                    sds_pkg::CL_PLAIN, sds_pkg::CL_DOT: begin
                        job.dots = 1'b1;
                        job.pass = 1'b1;
                        n_mode   = sds_pkg::M_MIDLINE;
                    end
                    sds_pkg::CL_END: begin
                        job.dots = 1'b1;
                        job.term = 1'b1;
                        n_mode   = sds_pkg::M_BOM;
                    end
                    sds_pkg::CL_LF: begin
                        if ((r_mode == sds_pkg::M_CRLF_DOT_CR) ||
                            (r_mode == sds_pkg::M_DOT_CR)) begin
                            job.dots = 1'b1;
                            n_mode   = sds_pkg::M_CRLF;
                        end
                    end
                    sds_pkg::CL_CR: begin
                        if (r_mode == sds_pkg::M_CRLF_DOT) n_mode = sds_pkg::M_CRLF_DOT_CR;
                        else if (r_mode == sds_pkg::M_DOT) n_mode = sds_pkg::M_DOT_CR;
                    end
                    default: ;
                endcase
                if (!job.dots) job.crlf = 1'b0;
            end
        endcase
    end

    assign o_job  = job;
    assign o_push = accept && (job.crlf || job.dots || job.pass || job.term);

endmodule
`default_nettype wire

[hw/rtl/sds_queue.sv]
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module sds_queue #(
    parameter int unsigned P_DEPTH = sds_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire sds_pkg::t_job  i_job,
    input  wire                 i_pop,
    output sds_pkg::t_job       o_head,
    output logic                o_empty,
    output logic                o_full
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    sds_pkg::t_job    r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sds_back.sv]
// Back end: expand the head job into bytes, one per cycle while the output is not stalled, into an output register.
`timescale 1ns / 1ps
`default_nettype none
module sds_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire sds_pkg::t_job  i_head,
    input  wire                 i_q_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_item,
    output logic                o_end_of_message
);

    logic [sds_pkg::NUM_POS-1:0] r_done;
    logic [sds_pkg::NUM_POS-1:0] pending, first, rest;
    logic [sds_pkg::POS_W-1:0]   idx;
    logic                        issue;
    logic                        r_valid, r_last, r_eom;
    logic [7:0]                  r_byte, n_byte;

    assign pending = sds_pkg::job_mask(i_head) & ~r_done;

    always_comb begin
        idx = '0;
        for (int i = sds_pkg::NUM_POS - 1; i >= 0; i--) begin
            if (pending[i]) idx = sds_pkg::POS_W'(i);
        end
    end

    assign first  = sds_pkg::NUM_POS'(1) << idx;
    assign rest   = pending & ~first;
    assign issue  = !i_q_empty && (!r_valid || i_ready);
    assign o_pop  = issue && (rest == '0);
    assign n_byte = (idx == sds_pkg::POS_W'(sds_pkg::POS_BYTE)) ? i_head.data
                                                              : sds_pkg::slot_byte(idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_done  <= (rest == '0) ? '0 : (r_done | first);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_byte <= n_byte;
            r_last <= (rest == '0);
            r_eom  <= (idx == sds_pkg::POS_W'(sds_pkg::POS_EOM));
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last_of_item   = r_last;
    assign o_end_of_message = r_eom;

endmodule
`default_nettype wire
